// ===== rtl/gacc_pkg.sv =====
package gacc_pkg;

	localparam int MAX_NODES   = 64;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int NCNT_W      = $clog2(MAX_NODES + 1);
	localparam int NCFG_W      = 7;
	localparam int NODES_RESET = 64;
	localparam int THR_W       = 15;
	localparam int WGT_W       = 16;
	localparam int FRAC_W      = 16;
	localparam int AVG_W       = FRAC_W + 1;
	localparam int IN_TDATA_W  = ((WGT_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((AVG_W + 7) / 8) * 8;
	localparam int CFG_W       = THR_W;
	localparam int IDX_W       = 1;

	localparam int CNT_W  = $clog2(MAX_NODES * MAX_NODES + 1);
	localparam int POP_W  = $clog2(MAX_NODES + 1);
	localparam int K_W    = $clog2(MAX_NODES);
	localparam int D_W    = 2 * K_W;
	localparam int CONN_W = $clog2(MAX_NODES * (MAX_NODES - 1) / 2 + 1);
	localparam int NUM_W  = CONN_W + AVG_W;
	localparam int SUM_W  = $clog2(MAX_NODES * (1 << FRAC_W) + 1);
	localparam int DCNT_W = $clog2(NUM_W + 1);

	localparam logic [IDX_W-1:0] REG_EDGE_THRESHOLD = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_NODE_COUNT     = IDX_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR,
		ST_RCHK,
		ST_RDIV,
		ST_REND,
		ST_ROW,
		ST_ROWD,
		ST_NB,
		ST_MUL,
		ST_CDIV,
		ST_ADV,
		ST_AINIT,
		ST_ADIV,
		ST_FIN
	} gacc_state_t;

	function automatic logic [NCNT_W-1:0] clamp_nodes(input logic [NCFG_W-1:0] v);
		int x;
		x = int'(v);
		if (x < 1) x = 1;
		if (x > MAX_NODES) x = MAX_NODES;
		return NCNT_W'(x);
	endfunction

	function automatic logic [POP_W-1:0] popcount(input logic [MAX_NODES-1:0] v);
		logic [POP_W-1:0] c;
		c = '0;
		for (int b = 0; b < MAX_NODES; b++) c = c + POP_W'(v[b]);
		return c;
	endfunction

	function automatic logic [NODE_W-1:0] lowest_set(input logic [MAX_NODES-1:0] v);
		logic [NODE_W-1:0] idx;
		idx = '0;
		for (int b = MAX_NODES - 1; b >= 0; b--) begin
			if (v[b]) idx = NODE_W'(b);
		end
		return idx;
	endfunction

	function automatic logic [MAX_NODES-1:0] above_mask(input logic [NODE_W-1:0] j);
		logic [MAX_NODES-1:0] m;
		for (int b = 0; b < MAX_NODES; b++) m[b] = (b > int'(j));
		return m;
	endfunction

	function automatic logic [MAX_NODES-1:0] below_mask(input logic [NCNT_W-1:0] n);
		logic [MAX_NODES-1:0] m;
		for (int b = 0; b < MAX_NODES; b++) m[b] = (b < int'(n));
		return m;
	endfunction

endpackage

// ===== rtl/gacc_ram.sv =====
module gacc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/graph_average_clustering_coefficient.sv =====
// Average local clustering coefficient of a thresholded graph. Weights arrive row-major, one
// signed weight per request, node_count by node_count of them; a weight whose magnitude reaches
// edge_threshold sets its bit in a one-row-per-node adjacency RAM. Each weight is a read and a
// write-back of its row through the RAM's single read port, and no new weight is taken until
// that write-back is done. The request that completes the matrix starts a pass over all nodes:
// per node a read of its row plus one row read per neighbour, then a division in the shared
// shift-subtract divider when the node has two or more neighbours; a final division of the
// sum by the node count gives the result (unsigned Q16, 65536 is 1.0), which is placed in the
// output register. Loading of the next matrix may start while that result waits. While a
// write of node_count is handled no weight is taken, and the load position is recomputed with
// the same divider. The RAM needs no clearing after reset.
module graph_average_clustering_coefficient import gacc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [15:0] weight
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [16:0] average_coefficient, rest zero
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	gacc_state_t st_q, st_d;

	logic [THR_W-1:0]     thr_q;
	logic [NCNT_W-1:0]    nodes_q;
	logic                 rep_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NODE_W-1:0]    row_q, col_q;
	logic [NODE_W-1:0]    wrow_s1, wcol_s1;
	logic                 wbit_s1, last_s1;
	logic [NODE_W-1:0]    i_q;
	logic [MAX_NODES-1:0] nb_q, pend_q, and_s2;
	logic [NODE_W-1:0]    j_s1;
	logic                 v_s1, v_s2;
	logic [K_W-1:0]       k_q;
	logic [CONN_W-1:0]    conn_q;
	logic [D_W-1:0]       d_q, rem_q;
	logic [NUM_W-1:0]     num_q;
	logic [DCNT_W-1:0]    dcnt_q;
	logic [SUM_W-1:0]     sum_q;
	logic [AVG_W-1:0]     out_q;
	logic                 m_tvalid_q;

	logic                 ram_we;
	logic [NODE_W-1:0]    ram_raddr;
	logic [MAX_NODES-1:0] ram_rdata, ram_wdata;

	logic                 accept, is_edge, col_last, mat_done, last_node, out_free, div_last;
	logic                 wr_thr, wr_nodes;
	logic [WGT_W-1:0]     mag;
	logic [CNT_W-1:0]     total, cnt_inc;
	logic [NODE_W-1:0]    low_j;
	logic [MAX_NODES-1:0] row_nb;
	logic [D_W:0]         rem_sh, rem_sub;
	logic                 rem_ge;

	assign accept   = s_tvalid && s_tready;
	assign wr_thr   = cfg_we && (cfg_index == REG_EDGE_THRESHOLD);
	assign wr_nodes = cfg_we && (cfg_index == REG_NODE_COUNT);

	// Full-scale negative weight wraps to 32768 as an unsigned magnitude, which is what we want.
	assign mag      = s_tdata[WGT_W-1] ? (WGT_W'(0) - s_tdata[WGT_W-1:0]) : s_tdata[WGT_W-1:0];
	assign is_edge  = mag >= WGT_W'(thr_q);
	assign total    = CNT_W'(nodes_q) * CNT_W'(nodes_q);
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign mat_done = cnt_inc == total;
	assign col_last = NCNT_W'(col_q) == nodes_q - NCNT_W'(1);
	assign last_node = NCNT_W'(i_q) == nodes_q - NCNT_W'(1);
	assign out_free = !m_tvalid_q || m_tready;
	assign div_last = dcnt_q == DCNT_W'(1);

	assign low_j  = lowest_set(pend_q);
	assign row_nb = ram_rdata & below_mask(nodes_q) & ~(MAX_NODES'(1) << i_q);

	// One restoring division step: the quotient shifts into num_q from the bottom.
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, d_q};
	assign rem_sub = rem_sh - {1'b0, d_q};

	always_comb begin
		ram_wdata          = ram_rdata;
		ram_wdata[wcol_s1] = wbit_s1;
	end

	always_comb begin
		case (st_q)
			ST_IDLE: ram_raddr = row_q;
			ST_NB:   ram_raddr = low_j;
			default: ram_raddr = i_q;
		endcase
	end

	always_comb begin
		st_d     = st_q;
		s_tready = 1'b0;
		ram_we   = 1'b0;
		case (st_q)
			ST_IDLE: begin
				s_tready = !rep_q;
				if (rep_q) st_d = ST_RCHK;
				else if (accept) st_d = ST_WR;
			end
			ST_WR: begin
				ram_we = 1'b1;
				st_d   = last_s1 ? ST_ROW : ST_IDLE;
			end
			ST_RCHK: st_d = (cnt_q >= total) ? ST_IDLE : ST_RDIV;
			ST_RDIV: if (div_last) st_d = ST_REND;
			ST_REND: st_d = ST_IDLE;
			ST_ROW:  st_d = ST_ROWD;
			ST_ROWD: st_d = ST_NB;
			ST_NB:   if (pend_q == '0 && !v_s1 && !v_s2) st_d = ST_MUL;
			ST_MUL:  st_d = (k_q > K_W'(1)) ? ST_CDIV : ST_ADV;
			ST_CDIV: if (div_last) st_d = ST_ADV;
			ST_ADV:  st_d = last_node ? ST_AINIT : ST_ROW;
			ST_AINIT: st_d = ST_ADIV;
			ST_ADIV: if (div_last) st_d = ST_FIN;
			ST_FIN:  if (out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			thr_q      <= THR_W'(1);
			nodes_q    <= clamp_nodes(NCFG_W'(NODES_RESET));
			rep_q      <= 1'b0;
			cnt_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			last_s1    <= 1'b0;
			i_q        <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			dcnt_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (wr_thr) thr_q <= cfg_data[THR_W-1:0];
			if (wr_nodes) nodes_q <= clamp_nodes(cfg_data[NCFG_W-1:0]);
			rep_q <= (rep_q && st_q != ST_RCHK) || wr_nodes;

			if (accept) begin
				last_s1 <= mat_done;
				if (mat_done) begin
					cnt_q <= '0;
					row_q <= '0;
					col_q <= '0;
				end else begin
					cnt_q <= cnt_inc;
					if (col_last) begin
						col_q <= '0;
						row_q <= row_q + NODE_W'(1);
					end else begin
						col_q <= col_q + NODE_W'(1);
					end
				end
			end
			// A changed node count drops a matrix that is already past its end.
			if (st_q == ST_RCHK && cnt_q >= total) begin
				cnt_q <= '0;
				row_q <= '0;
				col_q <= '0;
			end
			if (st_q == ST_REND) begin
				row_q <= num_q[NODE_W-1:0];
				col_q <= rem_q[NODE_W-1:0];
			end

			if (st_q == ST_WR && last_s1) i_q <= '0;
			if (st_q == ST_ADV && !last_node) i_q <= i_q + NODE_W'(1);

			v_s1 <= (st_q == ST_NB) && (pend_q != '0);
			v_s2 <= v_s1;

			if (st_q == ST_RCHK || st_q == ST_MUL || st_q == ST_AINIT) begin
				dcnt_q <= DCNT_W'(NUM_W);
			end else if (st_q == ST_RDIV || st_q == ST_CDIV || st_q == ST_ADIV) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end

			if (st_q == ST_FIN && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wrow_s1 <= row_q;
			wcol_s1 <= col_q;
			wbit_s1 <= is_edge;
		end
		case (st_q)
			ST_WR: if (last_s1) sum_q <= '0;
			ST_RCHK: begin
				num_q <= NUM_W'(cnt_q);
				rem_q <= '0;
				d_q   <= D_W'(nodes_q);
			end
			ST_ROWD: begin
				nb_q   <= row_nb;
				pend_q <= row_nb;
				k_q    <= K_W'(popcount(row_nb));
				conn_q <= '0;
			end
			ST_NB: begin
				// Neighbour rows stream out one per cycle; their common bits are counted later.
				if (pend_q != '0) begin
					pend_q[low_j] <= 1'b0;
					j_s1          <= low_j;
				end
				if (v_s1) and_s2 <= ram_rdata & nb_q & above_mask(j_s1);
				if (v_s2) conn_q <= conn_q + CONN_W'(popcount(and_s2));
			end
			ST_MUL: begin
				d_q   <= D_W'(k_q) * D_W'(k_q - K_W'(1));
				num_q <= (k_q > K_W'(1)) ? {conn_q, AVG_W'(0)} : '0;
				rem_q <= '0;
			end
			ST_RDIV, ST_CDIV, ST_ADIV: begin
				rem_q <= rem_ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
				num_q <= {num_q[NUM_W-2:0], rem_ge};
			end
			ST_ADV: sum_q <= sum_q + SUM_W'(num_q[AVG_W-1:0]);
			ST_AINIT: begin
				num_q <= NUM_W'(sum_q);
				rem_q <= '0;
				d_q   <= D_W'(nodes_q);
			end
			ST_FIN: if (out_free) out_q <= num_q[AVG_W-1:0];
			default: ;
		endcase
	end

	gacc_ram #(
		.WIDTH(MAX_NODES),
		.DEPTH(MAX_NODES)
	) u_adj_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wrow_s1),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);

	a_accept_writes: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> st_q == ST_WR)
		else $error("accepted request not followed by a row write-back");

	a_no_self_pair: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_NB |-> !pend_q[i_q])
		else $error("node listed among its own neighbours");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FIN |-> num_q <= NUM_W'(1 << FRAC_W))
		else $error("average exceeds 1.0");

	a_load_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE && !rep_q) |-> (NCNT_W'(row_q) < nodes_q && NCNT_W'(col_q) < nodes_q))
		else $error("load position outside the matrix");

endmodule
